>>> rtl/core/qedr_pkg.sv
// Shared types and constants for the quadrature encoder delta reader.
package qedr_pkg;

	localparam int unsigned ACC_WIDTH_DEF = 16;

	localparam int unsigned STEP_MODE_W = 2;
	localparam int unsigned CC_W        = 7;
	localparam int unsigned CFG_DATA_W  = 7;
	localparam int unsigned CFG_INDEX_W = 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CC_NUMBER = 1'd1;

	// Command codes.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [STEP_MODE_W-1:0] STEP_MODE_RESET = 2'd1;
	localparam logic [STEP_MODE_W-1:0] STEP_MODE_MAX   = 2'd2;
	localparam logic [CC_W-1:0]        CC_NUMBER_RESET = 7'd9;

	localparam int unsigned PHASE_A_BIT = 7;
	localparam int unsigned PHASE_B_BIT = 6;
	localparam int          STEP_CLAMP  = 63;
	localparam logic [CC_W-1:0] CC_OFFSET = 7'd64;

	typedef struct packed {
		logic signed [CC_W-1:0] step_value;
		logic [CC_W-1:0]        cc_value;
		logic [CC_W-1:0]        cc_number;
	} result_t;

endpackage

>>> rtl/core/quadrature_encoder_delta_reader_core.sv
// Quadrature encoder delta reader: phase decode, delta accumulator and CC output.
//
// Each accepted item is either a port sample (cmd 0) or a read (cmd 1), and the block takes
// one item per clock cycle while in_ready is high. A sample decodes the active-low A/B
// phases from bits 7 and 6, and a single-step phase change moves a saturating signed
// accumulator by one. A read clamps the accumulator to +/-63, divides it by the detent size
// (1, 2 or 4 from step_mode, rounded toward minus infinity), keeps only the remainder bits,
// and emits one result when the step is not zero. Results are registered in a two-entry
// output buffer, so input transfers continue while one result waits downstream;
// in_ready falls only when both entries are full. Configuration writes take effect on
// the next cycle.
module quadrature_encoder_delta_reader_core #(
	parameter int unsigned ACC_WIDTH = qedr_pkg::ACC_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic [7:0]                            port_byte,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [qedr_pkg::CC_W-1:0]      step_value,
	output logic [qedr_pkg::CC_W-1:0]             cc_value,
	output logic [qedr_pkg::CC_W-1:0]             cc_number,
	input  logic                                  cfg_we,
	input  logic [qedr_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [qedr_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_WIDTH-1:0] CLAMP_POS = ACC_WIDTH'(qedr_pkg::STEP_CLAMP);
	localparam logic signed [ACC_WIDTH-1:0] CLAMP_NEG = -CLAMP_POS;

	logic [qedr_pkg::STEP_MODE_W-1:0] step_mode_q;
	logic [qedr_pkg::CC_W-1:0]        cc_number_q;
	logic [1:0]                       last_phase_q;
	logic signed [ACC_WIDTH-1:0]      delta_sum_q;

	qedr_pkg::result_t out_q, skid_q, res;
	logic out_valid_q, skid_valid_q;

	logic                        accept;
	logic [1:0]                  phase;
	logic [1:0]                  diff;
	logic [1:0]                  shift;
	logic signed [6:0]           clamped;
	logic signed [7:0]           reduced;
	logic [ACC_WIDTH-1:0]        keep_mask;
	logic                        res_push;
	logic                        out_load_new, out_load_skid, skid_load;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_mode_q <= qedr_pkg::STEP_MODE_RESET;
			cc_number_q <= qedr_pkg::CC_NUMBER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qedr_pkg::REG_STEP_MODE: step_mode_q <= cfg_data[qedr_pkg::STEP_MODE_W-1:0];
				qedr_pkg::REG_CC_NUMBER: cc_number_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Phase decode: A active gives 3, B active flips the low bit.
	always_comb begin
		phase = {2{!port_byte[qedr_pkg::PHASE_A_BIT]}};
		phase[0] = phase[0] ^ !port_byte[qedr_pkg::PHASE_B_BIT];
		diff = last_phase_q - phase;
	end

	// Read path: clamp, then divide by the detent size rounding toward minus infinity.
	always_comb begin
		shift = (step_mode_q > qedr_pkg::STEP_MODE_MAX) ? qedr_pkg::STEP_MODE_MAX : step_mode_q;
		if (delta_sum_q > CLAMP_POS) begin
			clamped = 7'(qedr_pkg::STEP_CLAMP);
		end else if (delta_sum_q < CLAMP_NEG) begin
			clamped = -7'(qedr_pkg::STEP_CLAMP);
		end else begin
			clamped = delta_sum_q[6:0];
		end
		reduced   = 8'(clamped) >>> shift;
		keep_mask = ACC_WIDTH'((4'd1 << shift) - 4'd1);

		res.step_value = reduced[6:0];
		res.cc_value   = reduced[6:0] + qedr_pkg::CC_OFFSET;
		res.cc_number  = cc_number_q;
	end

	// Encoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= 2'd0;
			delta_sum_q  <= '0;
		end else if (accept) begin
			if (cmd == qedr_pkg::CMD_SAMPLE) begin
				if (diff[0]) begin
					last_phase_q <= phase;
					if (diff[1]) begin
						if (delta_sum_q != ACC_MAX) delta_sum_q <= delta_sum_q + 1'b1;
					end else begin
						if (delta_sum_q != ACC_MIN) delta_sum_q <= delta_sum_q - 1'b1;
					end
				end
			end else begin
				delta_sum_q <= delta_sum_q & keep_mask;
			end
		end
	end

	// Two-entry output buffer: the skid entry fills only while the head is stalled.
	always_comb begin
		res_push      = accept && (cmd == qedr_pkg::CMD_READ) && (reduced != 8'sd0);
		skid_load     = out_valid_q && !out_ready && res_push;
		out_load_skid = !(out_valid_q && !out_ready) && skid_valid_q;
		out_load_new  = !(out_valid_q && !out_ready) && !skid_valid_q && res_push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (skid_load) skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_load) skid_q <= res;
		if (out_load_skid) begin
			out_q <= skid_q;
		end else if (out_load_new) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign step_value = out_q.step_value;
	assign cc_value   = out_q.cc_value;
	assign cc_number  = out_q.cc_number;

endmodule

>>> rtl/core/qedr_checker.sv
// Port-level checker for the quadrature encoder delta reader, bound to the core module.
module qedr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [qedr_pkg::CC_W-1:0]  step_value,
	input logic [qedr_pkg::CC_W-1:0]         cc_value,
	input logic [qedr_pkg::CC_W-1:0]         cc_number
);

	// A result that is not taken holds still until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(step_value) && $stable(cc_value)
			&& $stable(cc_number))
		else $error("result changed while stalled");

	// A reported step is never zero and never beyond the clamp.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_value != 7'sd0 && step_value != -7'sd64)
		else $error("step_value out of range");

	// The CC data byte is the step offset by 64.
	a_cc_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cc_value == 7'(step_value + qedr_pkg::CC_OFFSET))
		else $error("cc_value does not match step_value");

	// Input stalls only while results are held for the consumer.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

endmodule

bind quadrature_encoder_delta_reader_core qedr_checker u_qedr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.step_value (step_value),
	.cc_value   (cc_value),
	.cc_number  (cc_number)
);
